// File: src/grid_local_peak_detector_top_macros.svh
// Assertion helpers for the grid peak detector.
// Both sample on the rising edge of clk and are held off while rst is high.
`ifndef GRID_LOCAL_PEAK_DETECTOR_TOP_MACROS_SVH
`define GRID_LOCAL_PEAK_DETECTOR_TOP_MACROS_SVH

// Condition that must hold at every edge.
`define GLPD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("grid peak detector: invariant violated");

// Consequence that must hold in the cycle after the antecedent.
`define GLPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid peak detector: sequencing check failed");

`endif

// File: src/glpd_pkg.sv
`default_nettype none

package glpd_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS  = 16;
  localparam int ROW_OUT_BITS = 10;
  localparam int COL_OUT_BITS = 10;
  localparam int CFG_BITS     = 11;

  // Register reset value (both counts)
  localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;

  // Register indexes, decoded from paddr[2]
  localparam logic [0:0] REG_ROW_COUNT = 1'b0;
  localparam logic [0:0] REG_COL_COUNT = 1'b1;

  // Item kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ROW_OUT_BITS-1:0] peak_row_t;
  typedef logic [COL_OUT_BITS-1:0] peak_col_t;

  typedef struct packed {
    logic    cmd;
    sample_t sample;
  } in_item_t;

  typedef struct packed {
    peak_row_t peak_row;
    peak_col_t peak_col;
    sample_t   peak_value;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/glpd_line_ram.sv
`default_nettype none

// One line store: one write and one registered read per cycle.
// A read of the address being written returns the new data.
module glpd_line_ram
  import glpd_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sample_t       wdata,
  input  logic [AW-1:0] raddr,
  output sample_t       rdata
);

  sample_t mem [DEPTH];

  // Write with bypass onto the read register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/glpd_cell.sv
`default_nettype none

// Window cell: holds one sample of the row above the current position.
// Takes its neighbour's value on a shift, or a fresh value at a row start.
module glpd_cell
  import glpd_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  logic    load,
  input  sample_t shift_in,
  input  sample_t load_in,
  output sample_t value
);

  always_ff @(posedge clk) begin
    if (en) begin
      value <= load ? load_in : shift_in;
    end
  end

endmodule

`default_nettype wire

// File: src/glpd_out_fifo.sv
`default_nettype none

// Two-entry result queue; full is registered and drives the input stall.
module glpd_out_fifo
  import glpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      valid,
  input  logic      stall,
  output out_item_t data,
  output logic      full
);

  out_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign pop   = valid && !stall;
  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign data  = slot[rd_ptr];

  // Occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/grid_local_peak_detector_top.sv
// Grid local peak detector.
// Samples enter in raster order on the item channel (item_valid, item_stall,
// item); after the last row the driver sends one flush request per column.
// A position is reported on the peak channel (peak_valid, peak_stall, peak)
// when it is >= each existing up, down, left and right neighbour, in raster
// order, at most one result per request.
// Throughput: one request per cycle while item_stall is low, set by the
// combinational window compare against two line stores, each read once and
// written once a cycle. Latency: a result is pushed at the edge that accepts
// the deciding request and shows on peak_valid in the next cycle.
// A two-entry result queue separates the channels; item_stall rises only
// while that queue is full, so a stalled receiver holds the input after two
// pending results.
// Reset (rst, synchronous) restores both counts to 1024 and the frame to its
// start; writing row_count (0x0) or col_count (0x4) over the APB port also
// restarts the frame. Line store contents are kept and need no clearing.
`default_nettype none
`include "grid_local_peak_detector_top_macros.svh"

module grid_local_peak_detector_top
  import glpd_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        peak_valid,
  input  logic        peak_stall,
  output out_item_t   peak,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS + 1);

  logic [CFG_BITS-1:0] row_count;
  logic [CFG_BITS-1:0] col_count;
  logic [RW-1:0]       row_pos;
  logic [RW-1:0]       row_pos_next;
  logic [CW-1:0]       col_pos;
  logic [CW-1:0]       col_pos_next;
  logic                bank;
  logic                bank_next;
  sample_t             head0;

  logic [RW-1:0]       rows;
  logic [CW:0]         cols;
  logic                cfg_wr;
  logic                item_acc;
  logic                is_flush;
  logic                flush_row;
  logic                adv;
  logic                last_col;
  logic                has_left;
  logic                has_up;
  logic                has_center;
  logic                peak_hit;
  logic                fifo_full;
  logic [RW-1:0]       row_m1;

  sample_t             down;
  sample_t             center;
  sample_t             left_val;
  sample_t             right_val;
  sample_t             up_val;
  sample_t             rdata0;
  sample_t             rdata1;
  sample_t             head_in;
  logic [CW-1:0]       raddr0;
  logic [CW-1:0]       raddr1;
  out_item_t           result;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CFG_RESET;
      col_count <= CFG_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROW_COUNT: row_count <= pwdata[CFG_BITS-1:0];
        REG_COL_COUNT: col_count <= pwdata[CFG_BITS-1:0];
        default:       row_count <= row_count;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_ROW_COUNT: prdata = 32'(row_count);
        REG_COL_COUNT: prdata = 32'(col_count);
        default:       prdata = 32'd0;
      endcase
    end
  end

  // Effective grid size: zero acts as one, clamp to the store size
  always_comb begin
    if (row_count == '0) begin
      rows = RW'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(row_count);
    end
    if (col_count == '0) begin
      cols = (CW+1)'(1);
    end else if (32'(col_count) > 32'(MAX_COLS)) begin
      cols = (CW+1)'(MAX_COLS);
    end else begin
      cols = (CW+1)'(col_count);
    end
  end

  // Request qualification
  assign item_acc   = item_valid && !item_stall;
  assign is_flush   = (item.cmd == CMD_FLUSH);
  assign flush_row  = (row_pos == rows);
  assign adv        = item_acc && (is_flush == flush_row);
  assign down       = item.sample;
  assign last_col   = ({1'b0, col_pos} == (cols - (CW+1)'(1)));
  assign has_left   = (col_pos != '0);
  assign has_up     = (32'(row_pos) >= 32'd2);
  assign has_center = (row_pos != '0);

  // Raster position and bank
  always_comb begin
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    bank_next    = bank;
    if (cfg_wr) begin
      col_pos_next = '0;
      row_pos_next = '0;
      bank_next    = 1'b0;
    end else if (adv) begin
      if (last_col) begin
        col_pos_next = '0;
        if (flush_row) begin
          row_pos_next = '0;
          bank_next    = 1'b0;
        end else begin
          row_pos_next = row_pos + RW'(1);
          bank_next    = ~bank;
        end
      end else begin
        col_pos_next = col_pos + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
      bank    <= 1'b0;
    end else begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
      bank    <= bank_next;
    end
  end

  // Line stores: the receiving bank fetches the next up value,
  // the other bank fetches the sample right of the next centre
  assign raddr0 = (bank_next == 1'b0) ? col_pos_next : col_pos_next + CW'(1);
  assign raddr1 = (bank_next == 1'b1) ? col_pos_next : col_pos_next + CW'(1);

  glpd_line_ram #(.DEPTH(MAX_COLS), .AW(CW)) u_store0 (
    .clk   (clk),
    .we    (adv && !is_flush && (bank == 1'b0)),
    .waddr (col_pos),
    .wdata (down),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  glpd_line_ram #(.DEPTH(MAX_COLS), .AW(CW)) u_store1 (
    .clk   (clk),
    .we    (adv && !is_flush && bank),
    .waddr (col_pos),
    .wdata (down),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  assign up_val    = bank ? rdata1 : rdata0;
  assign right_val = bank ? rdata0 : rdata1;

  // First sample of the row, becomes the centre at the next row start
  always_ff @(posedge clk) begin
    if (adv && !is_flush && (col_pos == '0)) begin
      head0 <= down;
    end
  end

  assign head_in = (cols == (CW+1)'(1)) ? down : head0;

  // Window chain: store read -> centre cell -> left cell
  glpd_cell u_cell_center (
    .clk      (clk),
    .en       (adv),
    .load     (last_col),
    .shift_in (right_val),
    .load_in  (head_in),
    .value    (center)
  );

  glpd_cell u_cell_left (
    .clk      (clk),
    .en       (adv),
    .load     (last_col),
    .shift_in (center),
    .load_in  (center),
    .value    (left_val)
  );

  // Four-neighbour compare, ties count as peaks
  assign peak_hit = has_center
                 && !(has_left && (center < left_val))
                 && !(!last_col && (center < right_val))
                 && !(has_up && (center < up_val))
                 && !(!is_flush && (center < down));

  assign row_m1            = row_pos - RW'(1);
  assign result.peak_row   = ROW_OUT_BITS'(row_m1);
  assign result.peak_col   = COL_OUT_BITS'(col_pos);
  assign result.peak_value = center;

  glpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && peak_hit),
    .push_data (result),
    .valid     (peak_valid),
    .stall     (peak_stall),
    .data      (peak),
    .full      (fifo_full)
  );

  assign item_stall = fifo_full;

  // Checks
  `GLPD_ASSERT_ALWAYS(a_col_in_range, (32'(col_pos) < 32'(cols)))
  `GLPD_ASSERT_ALWAYS(a_row_in_range, (row_pos <= rows))
  `GLPD_ASSERT_NEXT(a_frame_wrap, (adv && last_col && flush_row && !cfg_wr), ((row_pos == '0) && !bank))
  `GLPD_ASSERT_NEXT(a_bank_flip, (adv && last_col && !flush_row && !cfg_wr), (bank != $past(bank)))

endmodule

`default_nettype wire
